>>> rtl/core/vta_pkg.sv
// Shared types and constants for the virial tensor accumulator.
`timescale 1ns / 1ps

package vta_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ATOM  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Work queue between the front and the back.
  localparam int QPTR_W      = 2;
  localparam int QUEUE_DEPTH = 1 << QPTR_W;

  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         shift_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               last;
  } vta_in_t;

  typedef struct packed {
    logic signed [63:0] vir_xx;
    logic signed [63:0] vir_xy;
    logic signed [63:0] vir_xz;
    logic signed [63:0] vir_yx;
    logic signed [63:0] vir_yy;
    logic signed [63:0] vir_yz;
    logic signed [63:0] vir_zx;
    logic signed [63:0] vir_zy;
    logic signed [63:0] vir_zz;
  } vta_out_t;

  // One classified item for the back: either a virial clear or an atom
  // with its shifted position (x, y, z in elements 0, 1, 2) and force.
  typedef struct packed {
    logic             clear;
    logic             last;
    logic [2:0][31:0] spos;
    logic [2:0][31:0] frc;
  } vta_work_t;

endpackage

>>> rtl/core/vta_front.sv
// Front: accepts items, owns the shift table, forms shifted positions.
`timescale 1ns / 1ps

module vta_front #(
  parameter int SHIFT_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vta_pkg::vta_in_t   in_data,
  output logic               wk_valid,
  input  logic               wk_stall,
  output vta_pkg::vta_work_t wk_data
);
  import vta_pkg::*;

  localparam int AW = (SHIFT_ENTRIES > 1) ? $clog2(SHIFT_ENTRIES) : 1;

  logic [95:0]      shift_mem [0:SHIFT_ENTRIES-1];
  logic [95:0]      shift_rd_r;
  logic [AW-1:0]    addr;
  logic             in_range;
  logic             adv;
  logic             in_fire;
  logic             f1_valid_r;
  logic             f1_clear_r;
  logic             f1_last_r;
  logic             f1_in_range_r;
  logic [2:0][31:0] f1_pos_r;
  logic [2:0][31:0] f1_frc_r;
  logic             f2_valid_r;
  vta_work_t        f2_data_r;
  vta_work_t        f2_data_nxt;
  logic [2:0][31:0] shift_sel;

  function automatic logic [31:0] sat_diff32(logic [31:0] a, logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return d[31:0];
  endfunction

  // The whole front moves as one; it holds only while its last stage
  // has an item the queue cannot take.
  assign adv      = !(f2_valid_r && wk_stall);
  assign in_stall = !adv;
  assign in_fire  = in_valid && adv;
  assign in_range = ({4'b0, in_data.shift_index} < 9'(SHIFT_ENTRIES));
  assign addr     = AW'(in_data.shift_index);

  // A load writes at its own transfer, so an atom right behind it reads
  // the new entry.
  always_ff @(posedge clk) begin
    if (in_fire && in_data.operation == OP_LOAD && in_range) begin
      shift_mem[addr] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
    end
    if (adv) begin
      shift_rd_r <= shift_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= in_fire && (in_data.operation == OP_ATOM ||
                                in_data.operation == OP_CLEAR);
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_clear_r    <= (in_data.operation == OP_CLEAR);
      f1_last_r     <= in_data.last;
      f1_in_range_r <= in_range;
      f1_pos_r      <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
      f1_frc_r      <= {in_data.force_z, in_data.force_y, in_data.force_x};
      f2_data_r     <= f2_data_nxt;
    end
  end

  always_comb begin
    shift_sel[0] = f1_in_range_r ? shift_rd_r[95:64] : 32'd0;
    shift_sel[1] = f1_in_range_r ? shift_rd_r[63:32] : 32'd0;
    shift_sel[2] = f1_in_range_r ? shift_rd_r[31:0]  : 32'd0;
    f2_data_nxt.clear = f1_clear_r;
    f2_data_nxt.last  = f1_last_r;
    f2_data_nxt.frc   = f1_frc_r;
    for (int a = 0; a < 3; a++) begin
      f2_data_nxt.spos[a] = sat_diff32(f1_pos_r[a], shift_sel[a]);
    end
  end

  assign wk_valid = f2_valid_r;
  assign wk_data  = f2_data_r;

endmodule

>>> rtl/core/vta_queue.sv
// Short work queue that decouples the front from the back.
`timescale 1ns / 1ps

module vta_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vta_pkg::vta_work_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vta_pkg::vta_work_t out_data
);
  import vta_pkg::*;

  vta_work_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push;
  logic              pop;

  assign in_stall  = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

>>> rtl/core/vta_back.sv
// Back: outer products, saturating sums, virial update and result register.
`timescale 1ns / 1ps

module vta_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wk_valid,
  output logic               wk_stall,
  input  vta_pkg::vta_work_t wk_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vta_pkg::vta_out_t  out_data
);
  import vta_pkg::*;

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  logic             en;
  logic             b1_valid_r;
  logic             b1_clear_r;
  logic             b1_last_r;
  logic [8:0][63:0] prod_r;
  logic [8:0][63:0] prod_nxt;
  logic             b2_fire_r;
  logic             b2_clear_r;
  logic [8:0][63:0] half_r;
  logic [8:0][63:0] sums_r;
  logic [8:0][63:0] sum_new;
  logic [8:0][63:0] virial_r;
  logic [8:0][63:0] vir_new;
  logic             out_valid_r;

  function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic [63:0] sat_sub64(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  // The back advances as one unit and freezes only while a result waits.
  assign en       = !(out_valid_r && out_stall);
  assign wk_stall = !en;

  always_comb begin
    logic signed [31:0] d;
    logic signed [31:0] f;
    logic signed [63:0] p;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        d = wk_data.spos[a];
        f = wk_data.frc[b];
        p = d * f;
        prod_nxt[a * 3 + b] = p;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      sum_new[i] = sat_add64(sums_r[i], prod_r[i]);
      vir_new[i] = sat_sub64(virial_r[i], half_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_fire_r   <= 1'b0;
      b2_clear_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sums_r      <= '0;
      virial_r    <= '0;
    end else if (en) begin
      b1_valid_r <= wk_valid;
      b2_fire_r  <= b1_valid_r && !b1_clear_r && b1_last_r;
      b2_clear_r <= b1_valid_r && b1_clear_r;
      if (b1_valid_r && !b1_clear_r) begin
        sums_r <= b1_last_r ? '0 : sum_new;
      end
      out_valid_r <= b2_fire_r;
      if (b2_fire_r) begin
        virial_r <= vir_new;
      end else if (b2_clear_r) begin
        virial_r <= '0;
      end
    end
  end

  // Half of each finished sum, rounded toward minus infinity.
  always_ff @(posedge clk) begin
    if (en) begin
      b1_clear_r <= wk_data.clear;
      b1_last_r  <= wk_data.last;
      prod_r     <= prod_nxt;
      for (int i = 0; i < 9; i++) begin
        half_r[i] <= {sum_new[i][63], sum_new[i][63:1]};
      end
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_data.vir_xx = virial_r[0];
    out_data.vir_xy = virial_r[1];
    out_data.vir_xz = virial_r[2];
    out_data.vir_yx = virial_r[3];
    out_data.vir_yy = virial_r[4];
    out_data.vir_yz = virial_r[5];
    out_data.vir_zx = virial_r[6];
    out_data.vir_zy = virial_r[7];
    out_data.vir_zz = virial_r[8];
  end

endmodule

>>> rtl/core/virial_tensor_accumulator.sv
// Virial tensor accumulator over a run of atoms, with a shift-vector table.
//
// Takes one item per clock cycle at a sustained rate while in_stall is
// low. Load items write the shift table in the front and produce nothing.
// Atom and clear items pass through two front stages (table read, shifted
// position), a four-entry queue, and three back stages (nine parallel
// 32x32 multipliers, nine saturating 64-bit accumulators, virial update);
// the atom marked last presents the updated tensor in the result
// register. The result register holds the back while its result is
// stalled; the front keeps taking items until the queue fills. Clear items
// zero the virial tensor only, leaving running sums in place.
`timescale 1ns / 1ps

module virial_tensor_accumulator #(
  parameter int SHIFT_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vta_pkg::vta_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vta_pkg::vta_out_t out_data
);
  import vta_pkg::*;

  logic      fq_valid;
  logic      fq_stall;
  vta_work_t fq_data;
  logic      qb_valid;
  logic      qb_stall;
  vta_work_t qb_data;

  vta_front #(
    .SHIFT_ENTRIES(SHIFT_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .wk_valid (fq_valid),
    .wk_stall (fq_stall),
    .wk_data  (fq_data)
  );

  vta_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_stall  (fq_stall),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_stall (qb_stall),
    .out_data  (qb_data)
  );

  vta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wk_valid  (qb_valid),
    .wk_stall  (qb_stall),
    .wk_data   (qb_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> bench/virial_tensor_accumulator_tb.sv
// Self-checking testbench for the virial tensor accumulator, with its own tensor predictor.
`timescale 1ns / 1ps

module virial_tensor_accumulator_tb;
  import vta_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CALM_ITEMS   = 150;
  localparam int STALE_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  class virial_scoreboard;
    localparam int     SHIFT_ENTRIES = 32;
    localparam longint Q16_MAX = 64'sh000000007fffffff;
    localparam longint Q16_MIN = 64'shffffffff80000000;
    localparam longint S64_MAX = 64'sh7fffffffffffffff;
    localparam longint S64_MIN = 64'sh8000000000000000;

    int       shift_x [SHIFT_ENTRIES];
    int       shift_y [SHIFT_ENTRIES];
    int       shift_z [SHIFT_ENTRIES];
    longint   product_sum [9];
    longint   tensor [9];
    vta_out_t pending_tensors [$];
    int       error_count;

    function new();
      for (int k = 0; k < SHIFT_ENTRIES; k++) begin
        shift_x[k] = 0;
        shift_y[k] = 0;
        shift_z[k] = 0;
      end
      for (int k = 0; k < 9; k++) begin
        product_sum[k] = 0;
        tensor[k] = 0;
      end
      error_count = 0;
    endfunction

    function longint sat_sum(longint a, longint b);
      logic [64:0] w;
      w = {a[63], a} + {b[63], b};
      if (w[64] != w[63]) return w[64] ? S64_MIN : S64_MAX;
      return longint'(w[63:0]);
    endfunction

    function longint sat_diff(longint a, longint b);
      logic [64:0] w;
      w = {a[63], a} - {b[63], b};
      if (w[64] != w[63]) return w[64] ? S64_MIN : S64_MAX;
      return longint'(w[63:0]);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
    endtask

    // Updates the shadow state for one accepted transfer and queues the
    // tensor that the block must present, if any.
    function void predict_item(vta_in_t it);
      int       p [3];
      int       f [3];
      int       s [3];
      longint   d;
      longint   prod;
      vta_out_t want;
      p[0] = it.pos_x;
      p[1] = it.pos_y;
      p[2] = it.pos_z;
      f[0] = it.force_x;
      f[1] = it.force_y;
      f[2] = it.force_z;
      case (it.operation)
        OP_LOAD: begin
          if (it.shift_index < SHIFT_ENTRIES) begin
            shift_x[it.shift_index] = p[0];
            shift_y[it.shift_index] = p[1];
            shift_z[it.shift_index] = p[2];
          end
        end
        OP_CLEAR: begin
          for (int k = 0; k < 9; k++) tensor[k] = 0;
        end
        OP_ATOM: begin
          s = '{0, 0, 0};
          if (it.shift_index < SHIFT_ENTRIES) begin
            s[0] = shift_x[it.shift_index];
            s[1] = shift_y[it.shift_index];
            s[2] = shift_z[it.shift_index];
          end
          for (int a = 0; a < 3; a++) begin
            d = longint'(p[a]) - longint'(s[a]);
            if (d > Q16_MAX) d = Q16_MAX;
            else if (d < Q16_MIN) d = Q16_MIN;
            for (int b = 0; b < 3; b++) begin
              prod = d * longint'(f[b]);
              product_sum[a * 3 + b] = sat_sum(product_sum[a * 3 + b], prod);
            end
          end
          if (it.last) begin
            // Half of each sum rounds toward minus infinity.
            for (int k = 0; k < 9; k++) begin
              tensor[k] = sat_diff(tensor[k], product_sum[k] >>> 1);
              product_sum[k] = 0;
            end
            want.vir_xx = tensor[0];
            want.vir_xy = tensor[1];
            want.vir_xz = tensor[2];
            want.vir_yx = tensor[3];
            want.vir_yy = tensor[4];
            want.vir_yz = tensor[5];
            want.vir_zx = tensor[6];
            want.vir_zy = tensor[7];
            want.vir_zz = tensor[8];
            pending_tensors.push_back(want);
          end
        end
        default: ;
      endcase
    endfunction

    task check_tensor(vta_out_t got);
      vta_out_t    want;
      logic [575:0] got_bits;
      logic [575:0] want_bits;
      string       names [9] = '{"xx", "xy", "xz", "yx", "yy", "yz", "zx", "zy", "zz"};
      int          k;
      if (pending_tensors.size() == 0) begin
        report_mismatch("tensor transfer with no tensor expected");
        return;
      end
      want = pending_tensors.pop_front();
      got_bits = got;
      want_bits = want;
      for (k = 0; k < 9; k++) begin
        if (got_bits[575 - 64 * k -: 64] !== want_bits[575 - 64 * k -: 64])
          report_mismatch($sformatf("vir_%s got %h want %h", names[k],
                                    got_bits[575 - 64 * k -: 64],
                                    want_bits[575 - 64 * k -: 64]));
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  vta_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  vta_out_t out_data;

  virial_scoreboard tensor_board = new();

  logic [31:0] loaded_mask;
  bit          calm;
  int          gap_pct;
  int          stall_pct;
  int          sent_items;
  int          stale_cycles;

  virial_tensor_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic vta_in_t make_item(logic [1:0] op, logic [4:0] idx,
                                        logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                        logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                                        logic last);
    vta_in_t it;
    it.operation   = op;
    it.shift_index = idx;
    it.pos_x       = px;
    it.pos_y       = py;
    it.pos_z       = pz;
    it.force_x     = fx;
    it.force_y     = fy;
    it.force_z     = fz;
    it.last        = last;
    return it;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'h00000000;
      3, 4, 5: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
      default: return $urandom();
    endcase
  endfunction

  // Only entries already loaded may be applied to an atom.
  function automatic logic [4:0] pick_loaded();
    logic [4:0] idx;
    do idx = 5'($urandom_range(0, 31)); while (!loaded_mask[idx]);
    return idx;
  endfunction

  task automatic send_item(input vta_in_t it);
    int n;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    tensor_board.predict_item(it);
    if (it.operation == OP_LOAD) loaded_mask[it.shift_index] = 1'b1;
    if (it.operation != OP_UNUSED) sent_items++;
    if ($urandom_range(0, 39) == 0) gap_pct = $urandom_range(0, 2) * 30;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_phase();
    int r;
    int run_len;
    while (sent_items < RANDOM_ITEMS + 25) begin
      if (sent_items >= RANDOM_ITEMS + 25 - CALM_ITEMS) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(make_item(OP_LOAD, 5'($urandom_range(0, 31)), pick_value(), pick_value(),
                            pick_value(), pick_value(), pick_value(), pick_value(),
                            1'($urandom_range(0, 1))));
      end else if (r < 11) begin
        send_item(make_item(OP_CLEAR, 5'($urandom_range(0, 31)), pick_value(), pick_value(),
                            pick_value(), pick_value(), pick_value(), pick_value(),
                            1'($urandom_range(0, 1))));
      end else if (r < 13) begin
        send_item(make_item(OP_UNUSED, 5'($urandom_range(0, 31)), pick_value(), pick_value(),
                            pick_value(), pick_value(), pick_value(), pick_value(),
                            1'($urandom_range(0, 1))));
      end else begin
        // A run of atoms; now and then the closing atom lacks its last flag.
        run_len = $urandom_range(1, 8);
        for (int k = 0; k < run_len; k++)
          send_item(make_item(OP_ATOM, pick_loaded(), pick_value(), pick_value(),
                              pick_value(), pick_value(), pick_value(), pick_value(),
                              (k == run_len - 1) && ($urandom_range(0, 19) != 0)));
      end
    end
  endtask

  initial begin
    vta_in_t directed [$];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    loaded_mask = '0;
    calm        = 1'b0;
    gap_pct     = 30;
    sent_items  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_item(OP_LOAD, 5'd0, 32'h0, 32'h0, 32'h0,
                                 32'hffffffff, 32'h1, 32'h2, 1'b1));
    directed.push_back(make_item(OP_LOAD, 5'd31, 32'h80000000, 32'h7fffffff, 32'h00010000,
                                 32'h0, 32'h0, 32'h0, 1'b0));
    directed.push_back(make_item(OP_LOAD, 5'd1, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                                 32'h0, 32'h0, 32'h0, 1'b0));
    // Sums saturate high; three runs then drive the tensor to its low bound.
    for (int k = 0; k < 6; k++)
      directed.push_back(make_item(OP_ATOM, 5'd0, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000, 32'h80000000, 32'h80000000, k[0]));
    directed.push_back(make_item(OP_CLEAR, 5'd3, 32'h0, 32'h0, 32'h0,
                                 32'h0, 32'h0, 32'h0, 1'b1));
    // Shifted positions saturate both ways.
    directed.push_back(make_item(OP_ATOM, 5'd31, 32'h7fffffff, 32'h80000000, 32'h0,
                                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0));
    directed.push_back(make_item(OP_ATOM, 5'd1, 32'h80000000, 32'h7fffffff, 32'h0,
                                 32'h80000000, 32'h7fffffff, 32'h1, 1'b0));
    directed.push_back(make_item(OP_UNUSED, 5'd31, 32'h12345678, 32'h9abcdef0, 32'h1,
                                 32'h2, 32'h3, 32'h4, 1'b1));
    // A clear in the middle of a run keeps the running sums.
    directed.push_back(make_item(OP_CLEAR, 5'd0, 32'h0, 32'h0, 32'h0,
                                 32'h0, 32'h0, 32'h0, 1'b0));
    directed.push_back(make_item(OP_ATOM, 5'd0, 32'hffffffff, 32'h7fffffff, 32'h1,
                                 32'h1, 32'hffffffff, 32'h80000000, 1'b1));
    directed.push_back(make_item(OP_CLEAR, 5'd0, 32'h0, 32'h0, 32'h0,
                                 32'h0, 32'h0, 32'h0, 1'b0));
    // Sums saturate low; two runs drive the tensor to its high bound.
    for (int k = 0; k < 6; k++)
      directed.push_back(make_item(OP_ATOM, 5'd0, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, k == 2 || k == 5));
    directed.push_back(make_item(OP_ATOM, 5'd31, 32'h0, 32'h0, 32'h0,
                                 32'h0, 32'h0, 32'h0, 1'b1));
    directed.push_back(make_item(OP_ATOM, 5'd1, 32'hffffffff, 32'h00000001, 32'hfffe0000,
                                 32'h00000001, 32'hffffffff, 32'h00030000, 1'b1));
    foreach (directed[k]) send_item(directed[k]);

    random_phase();
    in_valid <= 1'b0;

    while (tensor_board.pending_tensors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tensor_board.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int span;
    out_stall = 1'b0;
    stall_pct = 30;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) stall_pct = $urandom_range(0, 2) * 30;
      span = $urandom_range(1, 13);
      out_stall <= !calm && ($urandom_range(0, 99) < stall_pct);
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tensor_board.check_tensor(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stale_cycles = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stale_cycles = 0;
    end else begin
      stale_cycles++;
      if (stale_cycles >= STALE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

>>> virial_tensor_accumulator.f
rtl/core/vta_pkg.sv
rtl/core/vta_front.sv
rtl/core/vta_queue.sv
rtl/core/vta_back.sv
rtl/core/virial_tensor_accumulator.sv
bench/virial_tensor_accumulator_tb.sv
